FILE: rtl/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

  // Input command codes
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } sfd_cmd_e;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SUM_GOOD = 8'hFF;

  // Results a single input item can cause
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic       checksum_ok;
  } sfd_result_t;

  // One queue entry: the results caused by one accepted item, slot 0 first
  typedef struct packed {
    logic [1:0]                        count;
    sfd_result_t [MAX_RESULTS-1:0]     res;
  } sfd_entry_t;

endpackage

FILE: rtl/sfd_if.sv
`timescale 1ns / 1ps

interface sfd_sextet_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [5:0] sextet;

  modport source (output valid, output cmd, output sextet, input ready);
  modport sink   (input valid, input cmd, input sextet, output ready);
endinterface

interface sfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic       checksum_ok;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  output checksum_ok, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  input checksum_ok, output ready);
endinterface

FILE: rtl/sfd_queue.sv
`timescale 1ns / 1ps

module sfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfd_pkg::sfd_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sfd_pkg::sfd_entry_t pop_data_o
);
  import sfd_pkg::*;

  sfd_entry_t           mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]  count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Every stored entry holds at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_data_i.count != 2'd0)
    else $error("empty entry pushed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

FILE: rtl/sfd_front.sv
`timescale 1ns / 1ps

module sfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfd_sextet_if.sink          in_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output sfd_pkg::sfd_entry_t push_data_o
);
  import sfd_pkg::*;

  logic [1:0] group_pos_q, group_pos_d;
  logic [5:0] partial_q [MAX_RESULTS];
  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic [7:0] sum_q, sum_d;

  logic       accept;
  logic [7:0] b0, b1, b2;
  logic [7:0] sum_full, sum_tail;
  sfd_entry_t entry;
  logic       want_push;

  function automatic sfd_result_t byte_res(input logic [7:0] b);
    sfd_result_t r;
    r.data_byte   = b;
    r.byte_valid  = 1'b1;
    r.last        = 1'b0;
    r.checksum_ok = 1'b0;
    return r;
  endfunction

  function automatic sfd_result_t status_res(input logic ok);
    sfd_result_t r;
    r.data_byte   = 8'h00;
    r.byte_valid  = 1'b0;
    r.last        = 1'b1;
    r.checksum_ok = ok;
    return r;
  endfunction

  assign in_i.ready = !queue_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Sextet bit layout of one group
  assign b0 = {partial_q[1][5:4], partial_q[0]};
  assign b1 = {partial_q[2][5:2], partial_q[1][3:0]};
  assign b2 = {in_i.sextet, partial_q[2][1:0]};

  assign sum_full = sum_q + b0 + b1 + b2;
  assign sum_tail = sum_q + ((group_pos_q >= 2'd2) ? b0 : 8'h00)
                          + ((group_pos_q == 2'd3) ? b1 : 8'h00);

  always_comb begin
    entry        = '0;
    want_push    = 1'b0;
    group_pos_d  = group_pos_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    sum_d        = sum_q;
    case (sfd_cmd_e'(in_i.cmd))
      CMD_DATA: begin
        if (group_pos_q == 2'd3) begin
          want_push = 1'b1;
          if (held_valid_q) begin
            entry.count  = 2'd3;
            entry.res[0] = byte_res(held_byte_q);
            entry.res[1] = byte_res(b0);
            entry.res[2] = byte_res(b1);
          end else begin
            entry.count  = 2'd2;
            entry.res[0] = byte_res(b0);
            entry.res[1] = byte_res(b1);
          end
          held_byte_d  = b2;
          held_valid_d = 1'b1;
          sum_d        = sum_full;
          group_pos_d  = 2'd0;
        end else begin
          group_pos_d = group_pos_q + 2'd1;
        end
      end
      CMD_END: begin
        want_push = 1'b1;
        case (group_pos_q)
          2'd3: begin
            if (held_valid_q) begin
              entry.count  = 2'd3;
              entry.res[0] = byte_res(held_byte_q);
              entry.res[1] = byte_res(b0);
              entry.res[2] = status_res(sum_tail == SUM_GOOD);
            end else begin
              entry.count  = 2'd2;
              entry.res[0] = byte_res(b0);
              entry.res[1] = status_res(sum_tail == SUM_GOOD);
            end
          end
          2'd2: begin
            if (held_valid_q) begin
              entry.count  = 2'd2;
              entry.res[0] = byte_res(held_byte_q);
              entry.res[1] = status_res(sum_tail == SUM_GOOD);
            end else begin
              entry.count  = 2'd1;
              entry.res[0] = status_res(sum_tail == SUM_GOOD);
            end
          end
          default: begin
            // lone or no trailing sextet: held byte is dropped
            entry.count  = 2'd1;
            entry.res[0] = status_res(sum_q == SUM_GOOD);
          end
        endcase
        group_pos_d  = 2'd0;
        held_byte_d  = 8'h00;
        held_valid_d = 1'b0;
        sum_d        = 8'h00;
      end
      default: ;
    endcase
  end

  assign push_o      = accept && want_push;
  assign push_data_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_pos_q  <= 2'd0;
      held_byte_q  <= 8'h00;
      held_valid_q <= 1'b0;
      sum_q        <= 8'h00;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        partial_q[i] <= 6'd0;
      end
    end else if (accept) begin
      group_pos_q  <= group_pos_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      sum_q        <= sum_d;
      if (in_i.cmd == CMD_DATA && group_pos_q != 2'd3) begin
        partial_q[group_pos_q] <= in_i.sextet;
      end
    end
  end

  // End of frame returns the decoder to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.cmd == CMD_END) |=> (group_pos_q == 2'd0 && !held_valid_q
                                          && sum_q == 8'h00))
    else $error("frame state not cleared after end of frame");

endmodule

FILE: rtl/sfd_back.sv
`timescale 1ns / 1ps

module sfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                queue_valid_i,
  input  sfd_pkg::sfd_entry_t queue_data_i,
  output logic                pop_o,
  sfd_result_if.source        out_o
);
  import sfd_pkg::*;

  logic        busy_q, busy_d;
  sfd_entry_t  cur_q, cur_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_xfer, last_slot, advance;
  sfd_result_t res;

  assign res       = cur_q.res[idx_q];
  assign out_xfer  = out_o.valid && out_o.ready;
  assign last_slot = (idx_q == cur_q.count - 2'd1);
  assign advance   = !busy_q || (out_xfer && last_slot);
  assign pop_o     = advance && queue_valid_i;

  assign out_o.valid       = busy_q;
  assign out_o.data_byte   = res.data_byte;
  assign out_o.byte_valid  = res.byte_valid;
  assign out_o.last        = res.last;
  assign out_o.checksum_ok = res.checksum_ok;

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    idx_d  = idx_q;
    if (advance) begin
      // load the next entry, or go idle once this one is drained
      busy_d = queue_valid_i;
      cur_d  = queue_data_i;
      idx_d  = 2'd0;
    end else if (out_xfer) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cur_q.count != 2'd0 && idx_q < cur_q.count))
    else $error("slot index outside entry");

  // The status result is never a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (!out_o.byte_valid && last_slot))
    else $error("status result misplaced");

endmodule

FILE: rtl/sixpack_frame_decoder.sv
`timescale 1ns / 1ps

// Frame decoder for 6-bit coded sextets.
// in_i carries one item per transfer: cmd selects a data sextet or the end of
// a frame. Every fourth data sextet completes a group of three bytes; the end
// of frame flushes a partial group and produces a closing status result.
// out_o carries one result per transfer: a payload byte (byte_valid high) or
// the closing status (last high, checksum_ok set when the byte sum is 0xFF).
// The final decoded byte of a frame is the checksum and is never sent.
// Throughput: the front takes one item per cycle while the queue is not full.
// One item can cause up to three results and the output sends one result per
// cycle while out_o is ready, so sustained rate is set by the result
// transfers; a two-entry queue sits between the front and the output stage.
// The first result of an item is registered in the queue and then in the
// output stage before it is offered on out_o.
// When out_o stalls, results wait in the output stage and the queue; in_i
// drops ready once the queue is full, and nothing is lost.
// Reset clears the group position, held byte and running sum; the first item
// can be taken as soon as reset is released.

module sixpack_frame_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_sextet_if.sink   in_i,
  sfd_result_if.source out_o
);
  import sfd_pkg::*;

  logic       push, full, pop, q_valid;
  sfd_entry_t push_data, pop_data;

  sfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  sfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  sfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (q_valid),
    .queue_data_i  (pop_data),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule
